>>> rtl/stmm_pkg.sv
`default_nettype none

package stmm_pkg;

  localparam int IDX_W     = 6;
  localparam int ENTRY_W   = 16;
  localparam int OUT_W     = 37;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    ACT_LOAD_A  = 2'd0,
    ACT_LOAD_B  = 2'd1,
    ACT_COMPUTE = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_DIM = 2'd1,
    ST_ROW = 2'd2,
    ST_OVF = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A_ROWS = 2'd0,
    REG_A_COLS = 2'd1,
    REG_B_ROWS = 2'd2,
    REG_B_COLS = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_A,
    S_SCAN_B,
    S_DRAIN,
    S_EMIT,
    S_ERR
  } state_e;

endpackage

`default_nettype wire

>>> rtl/stmm_if.sv
`default_nettype none

interface stmm_in_if
  import stmm_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [1:0]          action;
  logic [IDX_W-1:0]    row_index;
  logic [IDX_W-1:0]    col_index;
  logic signed [ENTRY_W-1:0] entry_value;

  modport source (output valid, action, row_index, col_index, entry_value, input ready);
  modport sink   (input valid, action, row_index, col_index, entry_value, output ready);
endinterface

interface stmm_out_if
  import stmm_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        out_col;
  logic signed [OUT_W-1:0] out_value;
  logic                    last;
  logic [1:0]              status;

  modport source (output valid, out_col, out_value, last, status, input ready);
  modport sink   (input valid, out_col, out_value, last, status, output ready);
endinterface

`default_nettype wire

>>> rtl/stmm_cell.sv
`default_nettype none

module stmm_cell
  import stmm_pkg::*;
#(
  parameter int MAX_DIM = 32,
  parameter int COL_IDX = 0,
  localparam int KW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    clear_i,
  input  wire logic                    shift_i,
  input  wire logic                    tok_vld_i,
  input  wire logic [KW-1:0]           tok_k_i,
  input  wire logic [KW-1:0]           tok_col_i,
  input  wire logic signed [OUT_W-1:0] tok_term_i,
  input  wire logic signed [OUT_W-1:0] acc_i,
  output logic                         tok_vld_o,
  output logic [KW-1:0]                tok_k_o,
  output logic [KW-1:0]                tok_col_o,
  output logic signed [OUT_W-1:0]      tok_term_o,
  output logic signed [OUT_W-1:0]      acc_o
);

  logic [MAX_DIM-1:0]      seen_q;
  logic signed [OUT_W-1:0] acc_q;
  logic                    tok_vld_q;
  logic [KW-1:0]           tok_k_q;
  logic [KW-1:0]           tok_col_q;
  logic signed [OUT_W-1:0] tok_term_q;
  logic                    hit;

  assign hit = tok_vld_i && (tok_col_i == KW'(COL_IDX)) && !seen_q[tok_k_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= '0;
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_vld_i;
      if (clear_i) begin
        seen_q <= '0;
      end else if (hit) begin
        seen_q[tok_k_i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tok_k_q    <= tok_k_i;
    tok_col_q  <= tok_col_i;
    tok_term_q <= tok_term_i;
    if (clear_i) begin
      acc_q <= '0;
    end else if (shift_i) begin
      acc_q <= acc_i;
    end else if (hit) begin
      acc_q <= acc_q + tok_term_i;
    end
  end

  assign tok_vld_o  = tok_vld_q;
  assign tok_k_o    = tok_k_q;
  assign tok_col_o  = tok_col_q;
  assign tok_term_o = tok_term_q;
  assign acc_o      = acc_q;

endmodule

`default_nettype wire

>>> rtl/sparse_triple_matrix_multiply_top.sv
// Sparse matrix multiplier over lists of (row, column, value) triples.
// Input channel in_i carries one word per request: load a triple into list A
// or list B, clear both lists, or compute one row of A x B. Loads and clears
// give no result. A compute request gives b_cols result words on out_o, one
// per column, the final one marked by last, or a single error word with a
// non-zero status.
// A compute scans list A once to build the dense row, then streams list B
// through a chain of MAX_DIM column cells, one triple per cycle. The first
// result word follows the scan of list A, the scan of list B and the drain
// of the chain; after it, one result per cycle while the receiver is ready.
// Loads are accepted while a result word still waits in the output register;
// a new request is taken only once the previous compute has left the chain.
// A stalled receiver holds the output register and the emission pauses.
// Reset empties both lists, clears the overflow flag and sets all four
// dimension registers to one. The triple memories are not cleared.
// The configuration port writes a register. The user must use it only while
// no request is in progress; the block itself does not enforce this.
`default_nettype none

module sparse_triple_matrix_multiply_top
  import stmm_pkg::*;
#(
  parameter int MAX_TERMS  = 64,
  parameter int MAX_DIM    = 32,
  parameter int VALUE_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [IDX_W-1:0]     cfg_wdata_i,
  stmm_in_if.sink                   in_i,
  stmm_out_if.source                out_o
);

  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int KW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int VB = VALUE_BITS;
  localparam int TW = 2 * IDX_W + VB;
  localparam int PW = 2 * VB;
  localparam int XW = (PW > OUT_W) ? PW : OUT_W;
  localparam int EV = (VB > ENTRY_W) ? VB : ENTRY_W;

  state_e state_q, state_d;

  logic [IDX_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  logic [CW-1:0]    a_cnt_q, b_cnt_q;
  logic             ovf_q;
  logic [IDX_W-1:0] row_q;
  logic [CW-1:0]    ptr_q, ptr_d;
  logic             rd_vld_q, rd_vld_d;
  logic [DW-1:0]    drain_q, drain_d;
  logic [IDX_W-1:0] col_q, col_d;
  status_e          err_q, err_d;

  logic [TW-1:0] a_mem [MAX_TERMS];
  logic [TW-1:0] b_mem [MAX_TERMS];
  logic [TW-1:0] a_rd_q, b_rd_q;
  logic          a_re, b_re;
  logic [TW-1:0] wr_triple;
  logic signed [EV-1:0] ent_ext;

  logic [MAX_DIM-1:0]    aseen_q;
  logic signed [VB-1:0]  arow_q [MAX_DIM];

  logic                 t_vld_q, t_vld_d;
  logic [KW-1:0]        t_k_q, t_col_q;
  logic signed [PW-1:0] t_prod_q;
  logic signed [XW-1:0] prod_ext;
  logic signed [OUT_W-1:0] term;

  logic                    out_vld_q;
  logic [IDX_W-1:0]        out_col_q;
  logic signed [OUT_W-1:0] out_val_q;
  logic                    out_last_q;
  status_e                 out_st_q;

  logic                    out_load;
  logic [IDX_W-1:0]        out_col_n;
  logic signed [OUT_W-1:0] out_val_n;
  logic                    out_last_n;
  status_e                 out_st_n;

  logic in_acc, slot_free, chain_clear, chain_shift;
  logic dim_bad, row_bad;
  logic a_hit;
  logic [IDX_W-1:0] a_row_f, a_col_f, b_row_f, b_col_f;
  logic [KW-1:0]    a_kidx, b_kidx, b_cidx;
  logic             b_in_range;

  logic                    tok_vld_w  [MAX_DIM];
  logic [KW-1:0]           tok_k_w    [MAX_DIM];
  logic [KW-1:0]           tok_col_w  [MAX_DIM];
  logic signed [OUT_W-1:0] tok_term_w [MAX_DIM];
  logic signed [OUT_W-1:0] acc_w      [MAX_DIM];
  logic                    chain_tail_vld;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign slot_free  = !out_vld_q || out_o.ready;

  assign dim_bad = (a_cols_q != b_rows_q)
                || (a_rows_q == '0) || (32'(a_rows_q) > MAX_DIM)
                || (a_cols_q == '0) || (32'(a_cols_q) > MAX_DIM)
                || (b_rows_q == '0) || (32'(b_rows_q) > MAX_DIM)
                || (b_cols_q == '0) || (32'(b_cols_q) > MAX_DIM);
  assign row_bad = (in_i.row_index == '0) || (in_i.row_index > a_rows_q);

  assign ent_ext   = EV'(in_i.entry_value);
  assign wr_triple = {in_i.row_index, in_i.col_index, ent_ext[VB-1:0]};

  assign a_row_f = a_rd_q[TW-1 -: IDX_W];
  assign a_col_f = a_rd_q[VB +: IDX_W];
  assign b_row_f = b_rd_q[TW-1 -: IDX_W];
  assign b_col_f = b_rd_q[VB +: IDX_W];
  assign a_kidx  = KW'(a_col_f - IDX_W'(1));
  assign b_kidx  = KW'(b_row_f - IDX_W'(1));
  assign b_cidx  = KW'(b_col_f - IDX_W'(1));

  assign a_hit = (state_q == S_SCAN_A) && rd_vld_q && (a_row_f == row_q)
              && (a_col_f != '0) && (a_col_f <= a_cols_q) && !aseen_q[a_kidx];
  assign b_in_range = (b_row_f != '0) && (b_row_f <= a_cols_q)
                   && (b_col_f != '0) && (b_col_f <= b_cols_q);

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    rd_vld_d    = 1'b0;
    drain_d     = drain_q;
    col_d       = col_q;
    err_d       = err_q;
    a_re        = 1'b0;
    b_re        = 1'b0;
    chain_clear = 1'b0;
    chain_shift = 1'b0;
    out_load    = 1'b0;
    out_col_n   = '0;
    out_val_n   = '0;
    out_last_n  = 1'b1;
    out_st_n    = ST_OK;
    t_vld_d     = (state_q == S_SCAN_B) && rd_vld_q && b_in_range;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (action_e'(in_i.action) == ACT_COMPUTE)) begin
          if (dim_bad) begin
            err_d   = ST_DIM;
            state_d = S_ERR;
          end else if (row_bad) begin
            err_d   = ST_ROW;
            state_d = S_ERR;
          end else if (ovf_q) begin
            err_d   = ST_OVF;
            state_d = S_ERR;
          end else begin
            state_d     = S_SCAN_A;
            ptr_d       = '0;
            chain_clear = 1'b1;
          end
        end
      end
      S_SCAN_A: begin
        if (ptr_q < a_cnt_q) begin
          a_re     = 1'b1;
          rd_vld_d = 1'b1;
          ptr_d    = ptr_q + CW'(1);
        end else if (!rd_vld_q) begin
          state_d = S_SCAN_B;
          ptr_d   = '0;
        end
      end
      S_SCAN_B: begin
        if (ptr_q < b_cnt_q) begin
          b_re     = 1'b1;
          rd_vld_d = 1'b1;
          ptr_d    = ptr_q + CW'(1);
        end else if (!rd_vld_q && !t_vld_q) begin
          state_d = S_DRAIN;
          drain_d = '0;
        end
      end
      S_DRAIN: begin
        if (drain_q == DW'(MAX_DIM)) begin
          state_d = S_EMIT;
          col_d   = IDX_W'(1);
        end else begin
          drain_d = drain_q + DW'(1);
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_load    = 1'b1;
          out_col_n   = col_q;
          out_val_n   = acc_w[0];
          out_last_n  = (col_q == b_cols_q);
          chain_shift = 1'b1;
          col_d       = col_q + IDX_W'(1);
          if (col_q == b_cols_q) begin
            state_d = S_IDLE;
          end
        end
      end
      S_ERR: begin
        if (slot_free) begin
          out_load = 1'b1;
          out_st_n = err_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      a_rows_q <= IDX_W'(1);
      a_cols_q <= IDX_W'(1);
      b_rows_q <= IDX_W'(1);
      b_cols_q <= IDX_W'(1);
      a_cnt_q  <= '0;
      b_cnt_q  <= '0;
      ovf_q    <= 1'b0;
      ptr_q    <= '0;
      rd_vld_q <= 1'b0;
      drain_q  <= '0;
      col_q    <= '0;
      err_q    <= ST_OK;
      t_vld_q  <= 1'b0;
      aseen_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      rd_vld_q <= rd_vld_d;
      drain_q  <= drain_d;
      col_q    <= col_d;
      err_q    <= err_d;
      t_vld_q  <= t_vld_d;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_A_ROWS: a_rows_q <= cfg_wdata_i;
          REG_A_COLS: a_cols_q <= cfg_wdata_i;
          REG_B_ROWS: b_rows_q <= cfg_wdata_i;
          REG_B_COLS: b_cols_q <= cfg_wdata_i;
        endcase
      end
      if (in_acc) begin
        case (action_e'(in_i.action))
          ACT_LOAD_A: begin
            if (a_cnt_q < CW'(MAX_TERMS)) begin
              a_cnt_q <= a_cnt_q + CW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
          end
          ACT_LOAD_B: begin
            if (b_cnt_q < CW'(MAX_TERMS)) begin
              b_cnt_q <= b_cnt_q + CW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
          end
          ACT_CLEAR: begin
            a_cnt_q <= '0;
            b_cnt_q <= '0;
            ovf_q   <= 1'b0;
          end
          default: ;
        endcase
      end
      if (chain_clear) begin
        aseen_q <= '0;
      end else if (a_hit) begin
        aseen_q[a_kidx] <= 1'b1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (action_e'(in_i.action) == ACT_COMPUTE)) begin
      row_q <= in_i.row_index;
    end
    if (a_hit) begin
      arow_q[a_kidx] <= $signed(a_rd_q[VB-1:0]);
    end
    t_k_q   <= b_kidx;
    t_col_q <= b_cidx;
    if (aseen_q[b_kidx]) begin
      t_prod_q <= arow_q[b_kidx] * $signed(b_rd_q[VB-1:0]);
    end else begin
      t_prod_q <= '0;
    end
    if (out_load) begin
      out_col_q  <= out_col_n;
      out_val_q  <= out_val_n;
      out_last_q <= out_last_n;
      out_st_q   <= out_st_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (action_e'(in_i.action) == ACT_LOAD_A) && (a_cnt_q < CW'(MAX_TERMS))) begin
      a_mem[a_cnt_q[AW-1:0]] <= wr_triple;
    end
    if (a_re) begin
      a_rd_q <= a_mem[ptr_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (action_e'(in_i.action) == ACT_LOAD_B) && (b_cnt_q < CW'(MAX_TERMS))) begin
      b_mem[b_cnt_q[AW-1:0]] <= wr_triple;
    end
    if (b_re) begin
      b_rd_q <= b_mem[ptr_q[AW-1:0]];
    end
  end

  assign prod_ext = XW'(t_prod_q);
  assign term     = prod_ext[OUT_W-1:0];

  for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
    logic                    vld_in;
    logic [KW-1:0]           k_in, col_in;
    logic signed [OUT_W-1:0] term_in, acc_in;

    if (g == 0) begin : g_head
      assign vld_in  = t_vld_q;
      assign k_in    = t_k_q;
      assign col_in  = t_col_q;
      assign term_in = term;
    end else begin : g_body
      assign vld_in  = tok_vld_w[g-1];
      assign k_in    = tok_k_w[g-1];
      assign col_in  = tok_col_w[g-1];
      assign term_in = tok_term_w[g-1];
    end

    if (g == MAX_DIM - 1) begin : g_tail
      assign acc_in = '0;
      assign chain_tail_vld = tok_vld_w[g];
    end else begin : g_mid
      assign acc_in = acc_w[g+1];
    end

    stmm_cell #(
      .MAX_DIM (MAX_DIM),
      .COL_IDX (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .clear_i    (chain_clear),
      .shift_i    (chain_shift),
      .tok_vld_i  (vld_in),
      .tok_k_i    (k_in),
      .tok_col_i  (col_in),
      .tok_term_i (term_in),
      .acc_i      (acc_in),
      .tok_vld_o  (tok_vld_w[g]),
      .tok_k_o    (tok_k_w[g]),
      .tok_col_o  (tok_col_w[g]),
      .tok_term_o (tok_term_w[g]),
      .acc_o      (acc_w[g])
    );
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.out_col   = out_col_q;
  assign out_o.out_value = out_val_q;
  assign out_o.last      = out_last_q;
  assign out_o.status    = out_st_q;

  a_emit_col_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> ((col_q != '0) && (col_q <= b_cols_q)))
    else $error("column counter left the result row");

  a_chain_drained : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> !chain_tail_vld)
    else $error("triple still in the cell chain while results are sent");

  a_err_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_st_q != ST_OK)) |-> ((out_col_q == '0) && out_last_q))
    else $error("error word is not a single final word");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_cnt_q <= CW'(MAX_TERMS)) && (b_cnt_q <= CW'(MAX_TERMS)))
    else $error("triple count beyond list capacity");

endmodule

`default_nettype wire
